>>> hw/rtl/sha_pkg.sv
package sha_pkg;

  // request passed from the front part to the back part
  typedef struct packed {
    logic       is_finish;
    logic [7:0] data;
  } sha_req_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_ROUNDS,
    ST_FINAL_ADD,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned ROUNDS = 64;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> hw/rtl/sha_front.sv
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [7:0]        in_data_byte,
  output logic              q_valid,
  output sha_pkg::sha_req_t q_req,
  input  logic              q_pop
);

  // two-entry request queue
  sha_pkg::sha_req_t mem_r [2];
  logic              wptr_r, rptr_r;
  logic [1:0]        cnt_r;
  logic              push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= '{is_finish: in_action, data: in_data_byte};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (q_pop) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> in_stall) else $error("full queue not stalling");

endmodule

>>> hw/rtl/sha_back.sv
module sha_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sha_pkg::sha_req_t q_req,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);

  sha_pkg::sha_state_t state_r, state_nxt;

  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  fill_r;
  logic [63:0] len_r;
  logic [5:0]  rnd_r;
  logic        fin_r;      // block in flight belongs to a finish
  logic        pad2_r;     // a second, length-only block follows
  logic [2:0]  oidx_r;

  logic [31:0] wt, w15, w2, g0, g1, s0, s1, ch, mj, t1, t2, wnew;
  logic        take_byte, start_fin;

  // schedule word for this round
  assign w15  = w_r[1];
  assign w2   = w_r[14];
  assign g0   = sha_pkg::ror(w15, 7) ^ sha_pkg::ror(w15, 18) ^ (w15 >> 3);
  assign g1   = sha_pkg::ror(w2, 17) ^ sha_pkg::ror(w2, 19) ^ (w2 >> 10);
  assign wnew = w_r[0] + g0 + w_r[9] + g1;
  assign wt   = w_r[0];

  // round function
  assign s1 = sha_pkg::ror(v_r[4], 6) ^ sha_pkg::ror(v_r[4], 11) ^ sha_pkg::ror(v_r[4], 25);
  assign ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1 = v_r[7] + s1 + ch + sha_pkg::K_TAB[rnd_r] + wt;
  assign s0 = sha_pkg::ror(v_r[0], 2) ^ sha_pkg::ror(v_r[0], 13) ^ sha_pkg::ror(v_r[0], 22);
  assign mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2 = s0 + mj;

  assign take_byte = (state_r == sha_pkg::ST_COLLECT) && q_valid && !q_req.is_finish;
  assign start_fin = (state_r == sha_pkg::ST_COLLECT) && q_valid && q_req.is_finish;

  assign out_valid       = (state_r == sha_pkg::ST_EMIT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  // next state and queue pop
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      sha_pkg::ST_COLLECT: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_req.is_finish) state_nxt = sha_pkg::ST_ROUNDS;
          else if (fill_r == 6'd63) state_nxt = sha_pkg::ST_ROUNDS;
        end
      end
      sha_pkg::ST_ROUNDS: begin
        if (rnd_r == 6'd63) state_nxt = sha_pkg::ST_FINAL_ADD;
      end
      sha_pkg::ST_FINAL_ADD: begin
        if (!fin_r) state_nxt = sha_pkg::ST_COLLECT;
        else if (pad2_r) state_nxt = sha_pkg::ST_PAD;
        else state_nxt = sha_pkg::ST_EMIT;
      end
      sha_pkg::ST_PAD: state_nxt = sha_pkg::ST_ROUNDS;
      sha_pkg::ST_EMIT: begin
        if (!out_stall && oidx_r == 3'd7) state_nxt = sha_pkg::ST_COLLECT;
      end
      default: state_nxt = sha_pkg::ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sha_pkg::ST_COLLECT;
    else        state_r <= state_nxt;
  end

  // control counters and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      rnd_r  <= '0;
      fin_r  <= 1'b0;
      pad2_r <= 1'b0;
      oidx_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::H_INIT[i];
    end else begin
      if (take_byte) begin
        fill_r <= fill_r + 6'd1;
        len_r  <= len_r + 64'd8;
        rnd_r  <= '0;
      end
      if (start_fin) begin
        fin_r  <= 1'b1;
        pad2_r <= (fill_r >= 6'd56);
        rnd_r  <= '0;
      end
      if (state_r == sha_pkg::ST_ROUNDS) rnd_r <= rnd_r + 6'd1;
      if (state_r == sha_pkg::ST_FINAL_ADD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (state_r == sha_pkg::ST_PAD) begin
        pad2_r <= 1'b0;
        rnd_r  <= '0;
      end
      if (state_r == sha_pkg::ST_EMIT && !out_stall) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::H_INIT[i];
          fill_r <= '0;
          len_r  <= '0;
          fin_r  <= 1'b0;
        end
      end
    end
  end

  // message window and working variables
  always_ff @(posedge clk) begin
    if (take_byte) begin
      w_r[fill_r[5:2]] <= (w_r[fill_r[5:2]] << 8) | {24'd0, q_req.data};
      if (fill_r == 6'd63) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
    end
    if (start_fin) begin
      // pad current block: 0x80 then zeros, length if it fits
      for (int j = 0; j < 16; j++) begin
        if (j > int'(fill_r[5:2])) w_r[j] <= '0;
      end
      case (fill_r[1:0])
        2'd0: w_r[fill_r[5:2]] <= {sha_pkg::PAD_BYTE, 24'd0};
        2'd1: w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][7:0], sha_pkg::PAD_BYTE, 16'd0};
        2'd2: w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][15:0], sha_pkg::PAD_BYTE, 8'd0};
        default: w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][23:0], sha_pkg::PAD_BYTE};
      endcase
      if (fill_r < 6'd56) begin
        w_r[14] <= len_r[63:32];
        w_r[15] <= len_r[31:0];
      end
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
    if (state_r == sha_pkg::ST_ROUNDS) begin
      for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
      w_r[15] <= wnew;
      for (int j = 1; j < 8; j++) v_r[j] <= v_r[j-1];
      v_r[4] <= v_r[3] + t1;
      v_r[0] <= t1 + t2;
    end
    if (state_r == sha_pkg::ST_PAD) begin
      for (int j = 0; j < 14; j++) w_r[j] <= '0;
      w_r[14] <= len_r[63:32];
      w_r[15] <= len_r[31:0];
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
  end

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(oidx_r)) else $error("emit lost");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == sha_pkg::ST_COLLECT) else $error("pop while busy");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_word |=> state_r == sha_pkg::ST_COLLECT)
    else $error("no return after digest");

endmodule

>>> hw/rtl/sha256_hash_core.sv
// channel | ports                                   | direction
// in      | in_valid in_stall in_action in_data_byte | request into core
// out     | out_valid out_stall out_digest_word      | digest words out
//         | out_word_index out_last_word             |
// data bytes fill the current block; the 64th byte of a block starts
// the round loop (one round per cycle through a single round unit)
// finish hashes one or two padded blocks, then emits the eight digest words
// rst_n is synchronous; it reloads the initial hash and clears length
// a two-entry queue decouples intake; in_stall rises only when it is full
// out_stall holds the current digest word until taken
module sha256_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic              q_valid, q_pop;
  sha_pkg::sha_req_t q_req;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_data_byte,
    .q_valid, .q_req, .q_pop
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_pop,
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_last_word
  );

endmodule
